[hdl/fbtt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbtt_pkg
// Shared types and constants for the frame brightness and threshold tuner.
// ----------------------------------------------------------------------------
package fbtt_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int COUNT_W    = 10;
    localparam int ENERGY_W   = 24;
    localparam int THRESH_W   = 8;
    localparam int CONTR_W    = 6;
    localparam int PIXEL_W    = 8;
    localparam int ACTION_W   = 3;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
    localparam logic [THRESH_W-1:0] THRESH_MAX = {THRESH_W{1'b1}};

    localparam logic [CONTR_W-1:0] CONTRAST_MIN  = 6'd4;
    localparam logic [CONTR_W-1:0] CONTRAST_MAX  = 6'd36;
    localparam logic [CONTR_W-1:0] CONTRAST_STEP = 6'd1;
    localparam logic [THRESH_W-1:0] THRESH_DOWN  = 8'd5;
    localparam logic [THRESH_W-1:0] THRESH_UP    = 8'd4;

    localparam logic [COUNT_W-1:0]  MIN_FEAT_RST   = 10'd22;
    localparam logic [COUNT_W-1:0]  MAX_FEAT_RST   = 10'd45;
    localparam logic [ENERGY_W-1:0] LOW_ENERGY_RST  = 24'd300000;
    localparam logic [ENERGY_W-1:0] HIGH_ENERGY_RST = 24'd450000;
    localparam logic [THRESH_W-1:0] MIN_THRESH_RST  = 8'd40;
    localparam logic [THRESH_W-1:0] MAX_THRESH_RST  = 8'd130;
    localparam logic [CONTR_W-1:0]  START_CONTR_RST = 6'd20;
    localparam logic [THRESH_W-1:0] START_THRESH_RST = 8'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_FEAT     = 3'd0,
        CFG_MAX_FEAT     = 3'd1,
        CFG_LOW_ENERGY   = 3'd2,
        CFG_HIGH_ENERGY  = 3'd3,
        CFG_MIN_THRESH   = 3'd4,
        CFG_MAX_THRESH   = 3'd5,
        CFG_START_CONTR  = 3'd6,
        CFG_START_THRESH = 3'd7
    } cfg_idx_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE        = 3'd0,
        ACT_CONTR_DOWN  = 3'd1,
        ACT_CONTR_UP    = 3'd2,
        ACT_THRESH_DOWN = 3'd3,
        ACT_THRESH_UP   = 3'd4
    } action_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  min_feat;
        logic [COUNT_W-1:0]  max_feat;
        logic [ENERGY_W-1:0] low_energy;
        logic [ENERGY_W-1:0] high_energy;
        logic [THRESH_W-1:0] min_thresh;
        logic [THRESH_W-1:0] max_thresh;
    } cfg_t;

    typedef struct packed {
        logic                keep;
        action_t             action;
        logic [CONTR_W-1:0]  contrast;
        logic [THRESH_W-1:0] threshold;
        logic [ENERGY_W-1:0] energy;
    } result_t;

endpackage

[hdl/fbtt_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbtt_cfg_regs
// Limit registers written through the plain configuration write port.
// ----------------------------------------------------------------------------
module fbtt_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fbtt_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [fbtt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output fbtt_pkg::cfg_t                    cfg
);

    fbtt_pkg::cfg_t cfg_reg;
    fbtt_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (fbtt_pkg::cfg_idx_t'(cfg_addr))
                fbtt_pkg::CFG_MIN_FEAT: begin
                    cfg_next.min_feat = cfg_wdata[fbtt_pkg::COUNT_W-1:0];
                end
                fbtt_pkg::CFG_MAX_FEAT: begin
                    cfg_next.max_feat = cfg_wdata[fbtt_pkg::COUNT_W-1:0];
                end
                fbtt_pkg::CFG_LOW_ENERGY: begin
                    cfg_next.low_energy = cfg_wdata[fbtt_pkg::ENERGY_W-1:0];
                end
                fbtt_pkg::CFG_HIGH_ENERGY: begin
                    cfg_next.high_energy = cfg_wdata[fbtt_pkg::ENERGY_W-1:0];
                end
                fbtt_pkg::CFG_MIN_THRESH: begin
                    cfg_next.min_thresh = cfg_wdata[fbtt_pkg::THRESH_W-1:0];
                end
                fbtt_pkg::CFG_MAX_THRESH: begin
                    cfg_next.max_thresh = cfg_wdata[fbtt_pkg::THRESH_W-1:0];
                end
                // start values are fixed constants loaded at reset; writes to them are ignored
                fbtt_pkg::CFG_START_CONTR: begin
                    cfg_next = cfg_reg;
                end
                fbtt_pkg::CFG_START_THRESH: begin
                    cfg_next = cfg_reg;
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_feat    <= fbtt_pkg::MIN_FEAT_RST;
            cfg_reg.max_feat    <= fbtt_pkg::MAX_FEAT_RST;
            cfg_reg.low_energy  <= fbtt_pkg::LOW_ENERGY_RST;
            cfg_reg.high_energy <= fbtt_pkg::HIGH_ENERGY_RST;
            cfg_reg.min_thresh  <= fbtt_pkg::MIN_THRESH_RST;
            cfg_reg.max_thresh  <= fbtt_pkg::MAX_THRESH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/fbtt_tuner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbtt_tuner
// Energy accumulator, contrast and threshold state, and the frame-end decision.
// ----------------------------------------------------------------------------
module fbtt_tuner (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              beat,
    input  logic                              cmd,
    input  logic [fbtt_pkg::PIXEL_W-1:0]      pixel,
    input  logic [fbtt_pkg::COUNT_W-1:0]      feature_count,
    input  fbtt_pkg::cfg_t                    cfg,
    output fbtt_pkg::result_t                 result
);

    logic [fbtt_pkg::ENERGY_W-1:0] energy_reg;
    logic [fbtt_pkg::ENERGY_W-1:0] energy_next;
    logic [fbtt_pkg::CONTR_W-1:0]  contrast_reg;
    logic [fbtt_pkg::CONTR_W-1:0]  contrast_next;
    logic [fbtt_pkg::THRESH_W-1:0] threshold_reg;
    logic [fbtt_pkg::THRESH_W-1:0] threshold_next;

    logic [fbtt_pkg::ENERGY_W:0]   sum_ext;
    logic [fbtt_pkg::THRESH_W+1:0] t_sub;
    logic [fbtt_pkg::THRESH_W:0]   t_add;
    logic [fbtt_pkg::CONTR_W-1:0]  c_new;
    logic [fbtt_pkg::THRESH_W-1:0] t_new;
    logic                          keep;
    fbtt_pkg::action_t             action;

    always_comb begin
        sum_ext = {1'b0, energy_reg} + {{(fbtt_pkg::ENERGY_W+1-fbtt_pkg::PIXEL_W){1'b0}}, pixel};
        t_sub   = {2'b00, threshold_reg} - {2'b00, fbtt_pkg::THRESH_DOWN};
        t_add   = {1'b0, threshold_reg} + {1'b0, fbtt_pkg::THRESH_UP};
        c_new   = contrast_reg;
        t_new   = threshold_reg;
        keep    = 1'b0;
        action  = fbtt_pkg::ACT_NONE;

        if (feature_count < cfg.min_feat) begin
            keep = 1'b1;
            if (energy_reg < cfg.low_energy) begin
                action = fbtt_pkg::ACT_CONTR_DOWN;
                if (contrast_reg < fbtt_pkg::CONTRAST_MIN + fbtt_pkg::CONTRAST_STEP) begin
                    c_new = fbtt_pkg::CONTRAST_MIN;
                    keep  = 1'b0;
                end else begin
                    c_new = contrast_reg - fbtt_pkg::CONTRAST_STEP;
                end
            end else if (energy_reg > cfg.high_energy) begin
                action = fbtt_pkg::ACT_CONTR_UP;
                if (contrast_reg >= fbtt_pkg::CONTRAST_MAX) begin
                    c_new = fbtt_pkg::CONTRAST_MAX;
                    keep  = 1'b0;
                end else begin
                    c_new = contrast_reg + fbtt_pkg::CONTRAST_STEP;
                end
            end else begin
                action = fbtt_pkg::ACT_THRESH_DOWN;
                // stop test uses the value before saturation
                if (t_sub[fbtt_pkg::THRESH_W+1]) begin
                    keep  = 1'b0;
                    t_new = '0;
                end else begin
                    t_new = t_sub[fbtt_pkg::THRESH_W-1:0];
                    if (t_new < cfg.min_thresh) begin
                        keep = 1'b0;
                    end
                end
            end
        end else if (feature_count > cfg.max_feat) begin
            if (threshold_reg <= cfg.max_thresh) begin
                action = fbtt_pkg::ACT_THRESH_UP;
                keep   = 1'b1;
                t_new  = t_add[fbtt_pkg::THRESH_W] ? fbtt_pkg::THRESH_MAX
                                                   : t_add[fbtt_pkg::THRESH_W-1:0];
            end
        end

        energy_next    = energy_reg;
        contrast_next  = contrast_reg;
        threshold_next = threshold_reg;
        if (beat) begin
            if (cmd) begin
                energy_next    = '0;
                contrast_next  = c_new;
                threshold_next = t_new;
            end else begin
                energy_next = sum_ext[fbtt_pkg::ENERGY_W] ? fbtt_pkg::ENERGY_MAX
                                                          : sum_ext[fbtt_pkg::ENERGY_W-1:0];
            end
        end

        result.keep      = keep;
        result.action    = action;
        result.contrast  = c_new;
        result.threshold = t_new;
        result.energy    = energy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            energy_reg    <= '0;
            contrast_reg  <= fbtt_pkg::START_CONTR_RST;
            threshold_reg <= fbtt_pkg::START_THRESH_RST;
        end else begin
            energy_reg    <= energy_next;
            contrast_reg  <= contrast_next;
            threshold_reg <= threshold_next;
        end
    end

endmodule

[hdl/frame_brightness_threshold_tuner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_brightness_threshold_tuner
// Sums pixel beats into a frame energy and, at each frame-end beat, tunes
// contrast and detector threshold and emits one result beat.
// ----------------------------------------------------------------------------
// a frame-end beat shows its result in the cycle after acceptance
// throughput: one input beat per cycle, set by the combinational decision path;
// pixel beats are taken, frame-end beats stalled, while a result waits on the output register
// reset (aresetn low, synchronous) clears the energy sum, restores all
// limits and loads the start contrast and threshold
module frame_brightness_threshold_tuner (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_cmd,
    input  logic [fbtt_pkg::PIXEL_W-1:0]      s_pixel,
    input  logic [fbtt_pkg::COUNT_W-1:0]      s_feature_count,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_keep_adjusting,
    output logic [fbtt_pkg::ACTION_W-1:0]     m_action,
    output logic [fbtt_pkg::CONTR_W-1:0]      m_contrast_level,
    output logic [fbtt_pkg::THRESH_W-1:0]     m_threshold_level,
    output logic [fbtt_pkg::ENERGY_W-1:0]     m_frame_energy,
    input  logic                              cfg_wr_en,
    input  logic [fbtt_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [fbtt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    fbtt_pkg::cfg_t    cfg;
    fbtt_pkg::result_t result;
    fbtt_pkg::result_t out_reg;
    fbtt_pkg::result_t out_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic              beat;

    assign s_ready = !m_valid_reg || m_ready || !s_cmd;
    assign beat    = s_valid && s_ready;

    fbtt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fbtt_tuner u_tuner (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .beat          (beat),
        .cmd           (s_cmd),
        .pixel         (s_pixel),
        .feature_count (s_feature_count),
        .cfg           (cfg),
        .result        (result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (beat && s_cmd) begin
            m_valid_next = 1'b1;
            out_next     = result;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_keep_adjusting  = out_reg.keep;
    assign m_action          = out_reg.action;
    assign m_contrast_level  = out_reg.contrast;
    assign m_threshold_level = out_reg.threshold;
    assign m_frame_energy    = out_reg.energy;

endmodule

[hdl/fbtt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbtt_checker
// Port-level checks for the tuner, attached to the top level by bind.
// ----------------------------------------------------------------------------
module fbtt_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              s_cmd,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic                              m_keep_adjusting,
    input logic [fbtt_pkg::ACTION_W-1:0]     m_action,
    input logic [fbtt_pkg::CONTR_W-1:0]      m_contrast_level,
    input logic [fbtt_pkg::ENERGY_W-1:0]     m_frame_energy
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_energy) && $stable(m_action))
        else $error("result beat changed while stalled");

    // a result only follows an accepted frame-end beat
    a_out_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_cmd))
        else $error("result beat without frame end");

    // contrast never leaves its clamp range
    a_contrast_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_contrast_level >= fbtt_pkg::CONTRAST_MIN)
                 && (m_contrast_level <= fbtt_pkg::CONTRAST_MAX))
        else $error("contrast out of range");

    // no action means tuning stops
    a_none_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_action == fbtt_pkg::ACT_NONE) |-> !m_keep_adjusting)
        else $error("keep set without action");

endmodule

bind frame_brightness_threshold_tuner fbtt_checker u_fbtt_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_cmd            (s_cmd),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_keep_adjusting (m_keep_adjusting),
    .m_action         (m_action),
    .m_contrast_level (m_contrast_level),
    .m_frame_energy   (m_frame_energy)
);
